/* hdl/fcr_pkg.sv */
// shared types and codes for the framed command receiver
`timescale 1ns / 1ps

package fcr_pkg;

    typedef struct packed
    {
        logic [7:0] rx_byte;
        logic       is_final;
    } byte_item_t;

    typedef struct packed
    {
        logic [2:0]  status;
        logic [7:0]  command;
        logic [7:0]  message_id;
        logic [7:0]  control;
        logic [7:0]  data0;
        logic [7:0]  data1;
        logic [7:0]  data2;
        logic [15:0] word12;
        logic [15:0] word34;
        logic [63:0] device_id;
        logic [2:0]  action;
    } frame_result_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_HEAD = 3'd1;
    localparam logic [2:0] ST_BAD_TAIL = 3'd2;
    localparam logic [2:0] ST_BAD_CRC  = 3'd3;
    localparam logic [2:0] ST_BAD_LEN  = 3'd4;

    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_ACTIVATED  = 3'd1;
    localparam logic [2:0] ACT_INACTIVE   = 3'd2;
    localparam logic [2:0] ACT_REG_FAILED = 3'd3;
    localparam logic [2:0] ACT_UPLOAD_OPT = 3'd4;
    localparam logic [2:0] ACT_DIFF_OPT   = 3'd5;
    localparam logic [2:0] ACT_ALARM_OPT  = 3'd6;
    localparam logic [2:0] ACT_SAMPLE     = 3'd7;

    localparam logic [7:0] CMD_REGISTER = 8'hA1;
    localparam logic [7:0] CMD_UPLOAD   = 8'h30;
    localparam logic [7:0] CMD_DIFF     = 8'h33;
    localparam logic [7:0] CMD_ALARM    = 8'h32;
    localparam logic [7:0] CMD_SAMPLE   = 8'hA5;

    localparam logic [7:0]  HEAD_BYTE = 8'h68;
    localparam logic [7:0]  TAIL_BYTE = 8'h16;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'h0000;

    localparam int MIN_FRAME  = 19;
    localparam int DATA_BYTES = 10;

endpackage

/* hdl/fcr_frame_core.sv */
// frame state, crc and result decode for one registered byte per cycle while step is high
`timescale 1ns / 1ps

module fcr_frame_core
    import fcr_pkg::*;
#(
    parameter int LEN_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  byte_item_t    item,
    output frame_result_t result
);

    localparam int IDX_LEN_HI = 3;
    localparam int IDX_LEN_LO = 4;
    localparam int IDX_MID    = 5;
    localparam int IDX_CTL    = 6;
    localparam int IDX_CMD    = 15;
    localparam int IDX_DATA   = 16;
    localparam logic [LEN_BITS-1:0] IDX_MAX = '1;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    logic [LEN_BITS-1:0] idx_reg, idx_next, idx_upd;
    logic [LEN_BITS-1:0] len_reg, len_next, len_upd;
    logic [15:0]         crc_reg, crc_next, crc_upd;
    logic                head_reg, head_next, head_upd;
    logic [15:0]         recent_reg, recent_next;
    logic [7:0]          mid_reg, mid_next, mid_upd;
    logic [7:0]          ctl_reg, ctl_next, ctl_upd;
    logic [7:0]          cmd_reg, cmd_next, cmd_upd;
    logic [7:0]          data_reg [DATA_BYTES];
    logic [7:0]          data_next [DATA_BYTES];
    logic [7:0]          data_upd [DATA_BYTES];

    logic       sat;
    logic       crc_hit;
    logic       fin;
    logic [7:0] b;
    logic [2:0] status;
    logic [2:0] action;

    always_comb
    begin
        b   = item.rx_byte;
        fin = item.is_final;
        sat = (idx_reg == IDX_MAX);

        head_upd = head_reg;
        len_upd  = len_reg;
        mid_upd  = mid_reg;
        ctl_upd  = ctl_reg;
        cmd_upd  = cmd_reg;
        for (int k = 0; k < DATA_BYTES; k++)
        begin
            data_upd[k] = data_reg[k];
        end

        if (!sat)
        begin
            if (idx_reg == '0)
            begin
                head_upd = (b == HEAD_BYTE);
            end
            if (idx_reg == LEN_BITS'(IDX_LEN_HI))
            begin
                len_upd = LEN_BITS'({b, 8'h00});
            end
            if (idx_reg == LEN_BITS'(IDX_LEN_LO))
            begin
                len_upd = len_reg | LEN_BITS'({8'h00, b});
            end
            if (idx_reg == LEN_BITS'(IDX_MID))
            begin
                mid_upd = b;
            end
            if (idx_reg == LEN_BITS'(IDX_CTL))
            begin
                ctl_upd = b;
            end
            if (idx_reg == LEN_BITS'(IDX_CMD))
            begin
                cmd_upd = b;
            end
            for (int k = 0; k < DATA_BYTES; k++)
            begin
                if (idx_reg == LEN_BITS'(IDX_DATA + k))
                begin
                    data_upd[k] = b;
                end
            end
        end

        crc_hit = !sat && (idx_reg >= LEN_BITS'(IDX_MID))
                  && (({1'b0, idx_reg} + (LEN_BITS+1)'(4)) <= {1'b0, len_upd});
        crc_upd = crc_hit ? crc_byte(crc_reg, b) : crc_reg;
        idx_upd = sat ? idx_reg : idx_reg + LEN_BITS'(1);

        // status in check order: head, tail, length, crc
        if (!head_upd)
        begin
            status = ST_BAD_HEAD;
        end
        else if (b != TAIL_BYTE)
        begin
            status = ST_BAD_TAIL;
        end
        else if ((idx_reg < LEN_BITS'(MIN_FRAME - 1)) || (len_upd < LEN_BITS'(MIN_FRAME)))
        begin
            status = ST_BAD_LEN;
        end
        else if (recent_reg != crc_upd)
        begin
            status = ST_BAD_CRC;
        end
        else
        begin
            status = ST_OK;
        end

        case (cmd_upd)
            CMD_REGISTER:
            begin
                if (data_upd[0] != 8'h00)
                begin
                    action = ACT_REG_FAILED;
                end
                else if (data_upd[1] == 8'h00)
                begin
                    action = ACT_INACTIVE;
                end
                else
                begin
                    action = ACT_ACTIVATED;
                end
            end
            CMD_UPLOAD: action = ACT_UPLOAD_OPT;
            CMD_DIFF:   action = ACT_DIFF_OPT;
            CMD_ALARM:  action = ACT_ALARM_OPT;
            CMD_SAMPLE: action = ACT_SAMPLE;
            default:    action = ACT_NONE;
        endcase

        result = '0;
        result.status = status;
        if (status == ST_OK)
        begin
            result.command    = cmd_upd;
            result.message_id = mid_upd;
            result.control    = ctl_upd;
            result.data0      = data_upd[0];
            result.data1      = data_upd[1];
            result.data2      = data_upd[2];
            result.word12     = {data_upd[1], data_upd[2]};
            result.word34     = {data_upd[3], data_upd[4]};
            result.device_id  = {data_upd[2], data_upd[3], data_upd[4], data_upd[5],
                                 data_upd[6], data_upd[7], data_upd[8], data_upd[9]};
            result.action     = action;
        end

        // frame end clears everything for the next frame
        if (fin)
        begin
            idx_next    = '0;
            len_next    = '0;
            crc_next    = CRC_INIT;
            head_next   = 1'b0;
            recent_next = '0;
            mid_next    = '0;
            ctl_next    = '0;
            cmd_next    = '0;
            for (int k = 0; k < DATA_BYTES; k++)
            begin
                data_next[k] = '0;
            end
        end
        else
        begin
            idx_next    = idx_upd;
            len_next    = len_upd;
            crc_next    = crc_upd;
            head_next   = head_upd;
            recent_next = {recent_reg[7:0], b};
            mid_next    = mid_upd;
            ctl_next    = ctl_upd;
            cmd_next    = cmd_upd;
            for (int k = 0; k < DATA_BYTES; k++)
            begin
                data_next[k] = data_upd[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            len_reg    <= '0;
            crc_reg    <= CRC_INIT;
            head_reg   <= 1'b0;
            recent_reg <= '0;
            mid_reg    <= '0;
            ctl_reg    <= '0;
            cmd_reg    <= '0;
            for (int k = 0; k < DATA_BYTES; k++)
            begin
                data_reg[k] <= '0;
            end
        end
        else if (step)
        begin
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            crc_reg    <= crc_next;
            head_reg   <= head_next;
            recent_reg <= recent_next;
            mid_reg    <= mid_next;
            ctl_reg    <= ctl_next;
            cmd_reg    <= cmd_next;
            for (int k = 0; k < DATA_BYTES; k++)
            begin
                data_reg[k] <= data_next[k];
            end
        end
    end

endmodule

/* hdl/framed_command_receiver_core.sv */
// top level of the framed command receiver: byte register, frame core, result register
`timescale 1ns / 1ps

// Takes one frame byte per transaction, head byte first, with is_final set on the tail
// byte, and gives one result transaction per frame: status and, for a good frame, header
// bytes, data bytes and action code. A byte can be taken in every cycle unless the result
// is stalled: each byte is registered, then the frame state, the one-byte crc-16 update
// and the result decode work on the registered byte, and the final byte's result goes to
// an output register. A stalled result holds the pipeline; the byte register still absorbs
// one more transaction. LEN_BITS sets the width of the byte counter and length field.

module framed_command_receiver_core
    import fcr_pkg::*;
#(
    parameter int LEN_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_stall,
    input  byte_item_t    byte_item,
    output logic          frame_valid,
    input  logic          frame_stall,
    output frame_result_t frame_result
);

    logic          item_valid_reg, item_valid_next;
    byte_item_t    item_reg;
    logic          frame_valid_reg, frame_valid_next;
    frame_result_t frame_reg;
    frame_result_t core_result;
    logic          advance;
    logic          step;
    logic          take;

    assign advance    = !frame_valid_reg || !frame_stall;
    assign step       = item_valid_reg && advance;
    assign byte_stall = item_valid_reg && !advance;
    assign take       = byte_valid && !byte_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (take)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        frame_valid_next = frame_valid_reg;
        if (advance)
        begin
            frame_valid_next = step && item_reg.is_final;
        end
    end

    fcr_frame_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg  <= item_valid_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= byte_item;
        end
        if (step && item_reg.is_final)
        begin
            frame_reg <= core_result;
        end
    end

    assign frame_valid  = frame_valid_reg;
    assign frame_result = frame_reg;

endmodule

/* hdl/fcr_checker.sv */
// port-level checks for the framed command receiver, bound to the top level
`timescale 1ns / 1ps

module fcr_checker
    import fcr_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          byte_valid,
    input logic          byte_stall,
    input byte_item_t    byte_item,
    input logic          frame_valid,
    input logic          frame_stall,
    input frame_result_t frame_result
);

    // a pending result transaction is held until taken
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_stall) |=> (frame_valid && $stable(frame_result)))
        else $error("result dropped or changed while stalled");

    // failed frames carry only a status
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_result.status != ST_OK)
        |-> (frame_result.command == 8'h00 && frame_result.message_id == 8'h00
             && frame_result.device_id == 64'h0 && frame_result.action == ACT_NONE))
        else $error("error result carries payload");

    // derived words agree with the data bytes
    a_words: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> (frame_result.word12 == {frame_result.data1, frame_result.data2}
                         && frame_result.device_id[63:56] == frame_result.data2
                         && frame_result.word34 == frame_result.device_id[55:40]))
        else $error("derived words inconsistent");

    // for register replies, action follows the first two data bytes
    a_action: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_result.status == ST_OK && frame_result.command == CMD_REGISTER)
        |-> ((frame_result.data0 != 8'h00 && frame_result.action == ACT_REG_FAILED)
             || (frame_result.data0 == 8'h00 && frame_result.data1 == 8'h00
                 && frame_result.action == ACT_INACTIVE)
             || (frame_result.data0 == 8'h00 && frame_result.data1 != 8'h00
                 && frame_result.action == ACT_ACTIVATED)))
        else $error("register reply action wrong");

endmodule

bind framed_command_receiver_core fcr_checker u_fcr_checker (.*);
